>>> rtl/dsdv_pkg.sv
// ----------------------------------------------------------------------------
// dsdv_pkg
// Shared types and constants of the distance-vector routing table.
// ----------------------------------------------------------------------------
package dsdv_pkg;

  localparam int TableEntriesDefault = 32;
  localparam int AddressBitsDefault  = 8;
  localparam int CostBitsDefault     = 16;
  localparam int SeqBits             = 16;
  localparam int ApbDataBits         = 32;
  localparam int ApbAddrBits         = 3;

  // Register index as decoded from the word address.
  localparam logic REG_OWN_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADVERT     = 2'd0,
    CMD_LINK_BREAK = 2'd1,
    CMD_LOOKUP     = 2'd2,
    CMD_DUMP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_OUT
  } state_e;

endpackage

>>> rtl/dsdv_if.sv
// ----------------------------------------------------------------------------
// dsdv_if
// Valid/ready channels for routing requests and reported routes.
// ----------------------------------------------------------------------------
interface dsdv_req_if #(
  parameter int ADDRESS_BITS = dsdv_pkg::AddressBitsDefault,
  parameter int COST_BITS    = dsdv_pkg::CostBitsDefault
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic                       first_of_advert;
  logic [ADDRESS_BITS-1:0]    neighbour;
  logic [COST_BITS-1:0]       link_cost;
  logic [ADDRESS_BITS-1:0]    destination;
  logic [COST_BITS-1:0]       advertised_cost;
  logic [dsdv_pkg::SeqBits-1:0] advertised_seq;

  modport source (output valid, command, first_of_advert, neighbour, link_cost,
                  destination, advertised_cost, advertised_seq, input ready);
  modport sink (input valid, command, first_of_advert, neighbour, link_cost,
                destination, advertised_cost, advertised_seq, output ready);
endinterface

interface dsdv_rsp_if #(
  parameter int ADDRESS_BITS = dsdv_pkg::AddressBitsDefault,
  parameter int COST_BITS    = dsdv_pkg::CostBitsDefault
);
  logic                         valid;
  logic                         ready;
  logic [ADDRESS_BITS-1:0]      route_destination;
  logic [ADDRESS_BITS-1:0]      next_hop;
  logic [COST_BITS-1:0]         route_cost;
  logic [dsdv_pkg::SeqBits-1:0] route_seq;
  logic                         found;
  logic                         last;
  logic                         broken_links;
  logic                         table_full;

  modport source (output valid, route_destination, next_hop, route_cost, route_seq,
                  found, last, broken_links, table_full, input ready);
  modport sink (input valid, route_destination, next_hop, route_cost, route_seq,
                found, last, broken_links, table_full, output ready);
endinterface

>>> rtl/dsdv_cell.sv
// ----------------------------------------------------------------------------
// dsdv_cell
// One route slot of the ring; takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module dsdv_cell #(
  parameter int SLOT_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic [SLOT_W-1:0] slot_o
);

  logic              valid_q;
  logic [SLOT_W-2:0] data_q;

  // The valid bit is the top bit of a slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= slot_i[SLOT_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i[SLOT_W-2:0];
    end
  end

  assign slot_o = {valid_q, data_q};

endmodule

>>> rtl/dsdv_routing_table.sv
// ----------------------------------------------------------------------------
// dsdv_routing_table
// Distance-vector routing table: slots rotate through a ring of cells past
// one update head that searches, merges, breaks links and dumps changes.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Carries
// req_i    in   valid/ready    command, advert entry or lookup target
// rsp_o    out  valid/ready    reported route, flags
// apb      in   psel/penable   own_address register
//
// Slot zero is this node, held as own_address; the ring has TABLE_ENTRIES-1
// cells. A command is accepted, rotates the ring once and then outputs its
// route; an advert entry adds a resolve step, and one that starts an
// advertisement adds a second rotation and resolve. A full output register
// stalls a dump's rotation and the output step. Reset clears the cell valid
// bits, so the block is ready after reset.
// ----------------------------------------------------------------------------
module dsdv_routing_table #(
  parameter int TABLE_ENTRIES = dsdv_pkg::TableEntriesDefault,
  parameter int ADDRESS_BITS  = dsdv_pkg::AddressBitsDefault,
  parameter int COST_BITS     = dsdv_pkg::CostBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dsdv_req_if.sink                          req_i,
  dsdv_rsp_if.source                        rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsdv_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [dsdv_pkg::ApbDataBits-1:0]  pwdata,
  output logic [dsdv_pkg::ApbDataBits-1:0]  prdata,
  output logic                              pready
);
  import dsdv_pkg::*;

  localparam int RING  = TABLE_ENTRIES - 1;
  localparam int IDX_W = (RING > 1) ? $clog2(RING) : 1;
  localparam int AB    = ADDRESS_BITS;
  localparam int CB    = COST_BITS;

  typedef struct packed {
    logic          valid;
    logic          changed;
    logic [AB-1:0] dest;
    logic [AB-1:0] hop;
    logic [CB-1:0] cost;
    logic [SeqBits-1:0] seq;
  } slot_t;

  typedef struct packed {
    logic [AB-1:0] dest;
    logic [AB-1:0] hop;
    logic [CB-1:0] cost;
    logic [SeqBits-1:0] seq;
    logic          found;
    logic          last;
    logic          broken;
    logic          full;
  } route_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(RING - 1);

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  logic              phase_nb_q, phase_nb_d;
  logic [AB-1:0]     nb_q, nb_d, dest_q, dest_d, own_q, own_d;
  logic [CB-1:0]     link_q, link_d, acost_q, acost_d;
  logic [SeqBits-1:0] aseq_q, aseq_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              hit_q, hit_d, free_v_q, free_v_d, pend_v_q, pend_v_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;
  slot_t             hit_rec_q, hit_rec_d, pend_rec_q, pend_rec_d;
  logic              nc_q, nc_d, broken_q, broken_d, full_q, full_d;
  route_t            held_q, held_d, out_q, out_d;
  logic              out_v_q, out_v_d;

  logic [SLOT_W-1:0] cell_q [RING];
  logic [SLOT_W-1:0] cell_d [RING];
  slot_t             cur, wb;
  logic [AB-1:0]     key;
  logic              accept, out_free, dump_emit, step, last_step, pend_here;
  logic [CB:0]       sum;
  logic [CB-1:0]     total;
  route_t            fin;
  logic              cfg_we;

  // ---------------------------------------------------------------- ring
  for (genvar i = 0; i < RING; i++) begin : g_cell
    if (i == RING - 1) begin : g_tail
      assign cell_d[i] = wb;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    dsdv_cell #(.SLOT_W(SLOT_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(step),
      .slot_i (cell_d[i]),
      .slot_o (cell_q[i])
    );
  end

  // ---------------------------------------------------------------- head
  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !out_v_q || rsp_o.ready;
  assign pend_here = pend_v_q && (pend_idx_q == cnt_q);
  assign cur       = pend_here ? pend_rec_q : slot_t'(cell_q[0]);
  assign key       = phase_nb_q ? nb_q : dest_q;
  assign dump_emit = (cmd_q == CMD_DUMP) && cur.valid && cur.changed;
  assign step      = (state_q == ST_SCAN) && (!dump_emit || out_free);
  assign last_step = (cnt_q == LastIdx);
  assign sum       = {1'b0, acost_q} + {1'b0, link_q};
  assign total     = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];

  always_comb begin
    wb = cur;
    unique case (cmd_q)
      CMD_LINK_BREAK: begin
        if (cur.valid && cur.hop == nb_q) begin
          wb.cost    = {CB{1'b1}};
          wb.seq     = cur.seq + SeqBits'(1);
          wb.changed = 1'b1;
        end
      end
      CMD_DUMP: wb.changed = 1'b0;
      default:  wb = cur;
    endcase
  end

  always_comb begin
    fin = held_q;
    unique case (cmd_q)
      CMD_LOOKUP: begin
        if (dest_q == own_q) begin
          fin = '{own_q, own_q, '0, '0, 1'b1, 1'b1, broken_q, 1'b0};
        end else if (hit_q) begin
          fin = '{dest_q, hit_rec_q.hop, hit_rec_q.cost, hit_rec_q.seq,
                  1'b1, 1'b1, broken_q, 1'b0};
        end else begin
          fin = '{dest_q, '0, {CB{1'b1}}, '0, 1'b0, 1'b1, broken_q, 1'b0};
        end
      end
      CMD_LINK_BREAK: fin = '{nb_q, '0, '0, '0, 1'b0, 1'b1, broken_q, 1'b0};
      CMD_DUMP:       fin.last = 1'b1;
      default:        fin = held_q;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if (step && last_step) begin
          state_d = (cmd_q == CMD_ADVERT) ? ST_RESOLVE : ST_OUT;
        end
      end
      ST_RESOLVE: state_d = phase_nb_q ? ST_SCAN : ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_we      = psel && penable && pwrite && pready && (paddr[2] == REG_OWN_ADDRESS);
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_OWN_ADDRESS) ?
                       ApbDataBits'(own_q) : '0;

  always_comb begin
    slot_t rec;
    logic  brk;
    cmd_d      = cmd_q;      phase_nb_d = phase_nb_q;
    nb_d       = nb_q;       dest_d     = dest_q;     own_d   = own_q;
    link_d     = link_q;     acost_d    = acost_q;    aseq_d  = aseq_q;
    cnt_d      = cnt_q;      hit_d      = hit_q;      free_v_d = free_v_q;
    hit_idx_d  = hit_idx_q;  free_idx_d = free_idx_q; hit_rec_d = hit_rec_q;
    pend_v_d   = pend_v_q;   pend_idx_d = pend_idx_q; pend_rec_d = pend_rec_q;
    nc_d       = nc_q;       broken_d   = broken_q;   full_d  = full_q;
    held_d     = held_q;     out_d      = out_q;
    out_v_d    = out_v_q && !rsp_o.ready;
    rec        = hit_rec_q;
    brk        = broken_q;

    if (cfg_we) begin
      own_d = pwdata[AB-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d      = cmd_e'(req_i.command);
          phase_nb_d = (cmd_e'(req_i.command) == CMD_ADVERT) && req_i.first_of_advert;
          nb_d       = req_i.neighbour;
          dest_d     = req_i.destination;
          link_d     = req_i.link_cost;
          acost_d    = req_i.advertised_cost;
          aseq_d     = req_i.advertised_seq;
          cnt_d      = '0;
          hit_d      = 1'b0;
          free_v_d   = 1'b0;
          full_d     = 1'b0;
          // A dump always reports this node first.
          held_d     = '{own_q, own_q, '0, '0, 1'b1, 1'b0, broken_q, 1'b0};
        end
      end
      ST_SCAN: begin
        if (step) begin
          cnt_d = last_step ? '0 : cnt_q + IDX_W'(1);
          if (!hit_q && cur.valid && cur.dest == key) begin
            hit_d     = 1'b1;
            hit_idx_d = cnt_q;
            hit_rec_d = cur;
          end
          if (!free_v_q && !cur.valid) begin
            free_v_d   = 1'b1;
            free_idx_d = cnt_q;
          end
          if (pend_here) begin
            pend_v_d = 1'b0;
          end
          if (cmd_q == CMD_LINK_BREAK && cur.valid && cur.hop == nb_q) begin
            broken_d = 1'b1;
          end
          if (dump_emit) begin
            out_v_d = 1'b1;
            out_d   = held_q;
            held_d  = '{cur.dest, cur.hop, cur.cost, cur.seq, 1'b1, 1'b0, broken_q, 1'b0};
          end
        end
      end
      ST_RESOLVE: begin
        if (phase_nb_q) begin
          if (nb_q == own_q) begin
            nc_d = (aseq_q != '0);
          end else if (hit_q) begin
            nc_d = (aseq_q > hit_rec_q.seq);
          end else begin
            nc_d = 1'b1;
            if (free_v_q) begin
              pend_v_d   = 1'b1;
              pend_idx_d = free_idx_q;
              pend_rec_d = '{1'b1, 1'b1, nb_q, nb_q, link_q, aseq_q};
            end else begin
              full_d = 1'b1;
            end
          end
          phase_nb_d = 1'b0;
          hit_d      = 1'b0;
          free_v_d   = 1'b0;
        end else begin
          if (dest_q == own_q) begin
            brk    = broken_q | aseq_q[0];
            held_d = '{own_q, own_q, '0, '0, 1'b1, 1'b1, brk, full_q};
          end else if (!hit_q) begin
            if (free_v_q) begin
              pend_v_d   = 1'b1;
              pend_idx_d = free_idx_q;
              pend_rec_d = '{1'b1, 1'b1, dest_q, nb_q, total, aseq_q};
              held_d     = '{dest_q, nb_q, total, aseq_q, 1'b1, 1'b1, broken_q, full_q};
            end else begin
              held_d = '{dest_q, '0, {CB{1'b1}}, '0, 1'b0, 1'b1, broken_q, 1'b1};
            end
          end else begin
            // Same hop with a refreshed neighbour wins over the sequence rules.
            if (hit_rec_q.hop == nb_q && nc_q) begin
              rec.cost    = total;
              rec.changed = 1'b1;
            end else if (aseq_q > hit_rec_q.seq) begin
              if (hit_rec_q.cost == {CB{1'b1}} && acost_q != {CB{1'b1}}) begin
                brk = 1'b1;
              end
              rec.cost = total;
              if (acost_q == {CB{1'b1}}) begin
                rec.cost = {CB{1'b1}};
                brk      = 1'b1;
              end
              rec.hop     = nb_q;
              rec.seq     = aseq_q;
              rec.changed = 1'b1;
            end else if (aseq_q == hit_rec_q.seq && hit_rec_q.cost >= total) begin
              rec.hop     = nb_q;
              rec.cost    = total;
              rec.changed = 1'b1;
            end
            pend_v_d   = 1'b1;
            pend_idx_d = hit_idx_q;
            pend_rec_d = rec;
            held_d     = '{dest_q, rec.hop, rec.cost, rec.seq, 1'b1, 1'b1, brk, full_q};
          end
          broken_d = brk;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = fin;
          if (cmd_q == CMD_DUMP) begin
            broken_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      nc_q     <= 1'b0;
      broken_q <= 1'b0;
      out_v_q  <= 1'b0;
      own_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      nc_q     <= nc_d;
      broken_q <= broken_d;
      out_v_q  <= out_v_d;
      own_q    <= own_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;      phase_nb_q <= phase_nb_d;
    nb_q       <= nb_d;       dest_q     <= dest_d;
    link_q     <= link_d;     acost_q    <= acost_d;    aseq_q   <= aseq_d;
    hit_q      <= hit_d;      free_v_q   <= free_v_d;
    hit_idx_q  <= hit_idx_d;  free_idx_q <= free_idx_d; hit_rec_q <= hit_rec_d;
    pend_idx_q <= pend_idx_d; pend_rec_q <= pend_rec_d;
    full_q     <= full_d;     held_q     <= held_d;     out_q    <= out_d;
  end

  assign rsp_o.valid             = out_v_q;
  assign rsp_o.route_destination = out_q.dest;
  assign rsp_o.next_hop          = out_q.hop;
  assign rsp_o.route_cost        = out_q.cost;
  assign rsp_o.route_seq         = out_q.seq;
  assign rsp_o.found             = out_q.found;
  assign rsp_o.last              = out_q.last;
  assign rsp_o.broken_links      = out_q.broken;
  assign rsp_o.table_full        = out_q.full;

  // ---------------------------------------------------------------- checks
  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> cnt_q == '0)
    else $error("ring not aligned while idle");

  a_pend_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_step |=> !pend_v_q)
    else $error("pending slot write survived a full rotation");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.found |-> rsp_o.last)
    else $error("miss item not marked last");

endmodule
